/* hw/rtl/scma_pkg.sv */
// ----------------------------------------------------------------------------
// scma_pkg
// Shared types and codes for the sparse coordinate matrix add unit.
// ----------------------------------------------------------------------------
package scma_pkg;

  localparam int COORD_W = 16;
  localparam int VAL_W   = 16;
  localparam int SUM_W   = 17;
  localparam int CFG_W   = 16;
  localparam int CFG_AW  = 2;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int IN_DW   = 48;
  localparam int OUT_DW  = 56;

  // func codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MERGE  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_ENTRY    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISMATCH = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_AW-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_AW-1:0] REG_COLS_B = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic              load_a;
    logic              load_b;
    logic              start;
    logic              fetch;
    logic              emit_entry;
    logic              emit_status;
    logic [STAT_W-1:0] status;
    logic              clear;
  } scma_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dims_differ;
    logic both_empty;
    logic out_free;
    logic merge_done;
  } scma_stat_t;

endpackage

/* hw/rtl/sparse_coordinate_matrix_add_unit.sv */
// Load beats are accepted back to back while no merge is in progress.
// For each emitted entry a merge does a registered list read, then a compare/add
// into the output register; output stalls hold the merge in place.
// The first merged entry is read in the start state, then written from the emit state.
// Mismatch or empty merges give their single result from the start state.
// Reset (rst_n, synchronous): counts cleared, dimensions set to 1, lists undefined.
// ----------------------------------------------------------------------------
// sparse_coordinate_matrix_add_unit
// Adds two coordinate-list sparse matrices by a two-pointer merge.
// ----------------------------------------------------------------------------
module sparse_coordinate_matrix_add_unit #(
  parameter int MAX_TERMS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [scma_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [scma_pkg::CFG_W-1:0]  cfg_wdata,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [scma_pkg::IN_DW-1:0]  in_tdata,   // row[15:0], col[31:16], value[47:32]
  input  logic [scma_pkg::FUNC_W-1:0] in_tuser,   // func[1:0]
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [scma_pkg::OUT_DW-1:0] out_tdata,  // out_row[15:0], out_col[31:16],
                                                  // out_value[48:32], zero pad
  output logic [scma_pkg::STAT_W-1:0] out_tuser,  // status[1:0]
  output logic                        out_tlast
);
  import scma_pkg::*;

  scma_cmd_t  cmd;
  scma_stat_t stat;

  // controller
  scma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  scma_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_data    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

/* hw/rtl/scma_ctrl.sv */
// ----------------------------------------------------------------------------
// scma_ctrl
// Sequencer for loads, the merge walk and the special-case results.
// ----------------------------------------------------------------------------
module scma_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [scma_pkg::FUNC_W-1:0] in_func,
  output logic                       in_ready,
  input  scma_pkg::scma_stat_t       stat,
  output scma_pkg::scma_cmd_t        cmd
);
  import scma_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_func)
            FUNC_LOAD_A: cmd.load_a = 1'b1;
            FUNC_LOAD_B: cmd.load_b = 1'b1;
            FUNC_MERGE: begin
              cmd.start = 1'b1;
              state_nxt = ST_START;
            end
            default: ;
          endcase
        end
      end
      ST_START: begin
        if (stat.dims_differ || stat.both_empty) begin
          if (stat.out_free) begin
            cmd.emit_status = 1'b1;
            cmd.status      = stat.dims_differ ? STAT_MISMATCH : STAT_EMPTY;
            cmd.clear       = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else begin
          cmd.fetch = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_entry = 1'b1;
          if (stat.merge_done) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/scma_dp.sv */
// ----------------------------------------------------------------------------
// scma_dp
// List storage, counts, merge pointers, compare/add and the output register.
// ----------------------------------------------------------------------------
module scma_dp #(
  parameter int MAX_TERMS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [scma_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [scma_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic [scma_pkg::IN_DW-1:0]  in_data,
  input  scma_pkg::scma_cmd_t         cmd,
  output scma_pkg::scma_stat_t        stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scma_pkg::OUT_DW-1:0] out_data,
  output logic [scma_pkg::STAT_W-1:0] out_status,
  output logic                        out_last
);
  import scma_pkg::*;

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

  // configuration registers
  logic [CFG_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= CFG_W'(1);
      cols_a_r <= CFG_W'(1);
      rows_b_r <= CFG_W'(1);
      cols_b_r <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROWS_A: rows_a_r <= cfg_wdata;
        REG_COLS_A: cols_a_r <= cfg_wdata;
        REG_ROWS_B: rows_b_r <= cfg_wdata;
        REG_COLS_B: cols_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // list memories, one write and one registered read each
  logic [IN_DW-1:0] mem_a [MAX_TERMS];
  logic [IN_DW-1:0] mem_b [MAX_TERMS];
  logic [IN_DW-1:0] a_q_r, b_q_r;
  logic [CNT_W-1:0] cnt_a_r, cnt_b_r;
  logic [CNT_W-1:0] i_r, j_r, i_nxt, j_nxt;

  always_ff @(posedge clk) begin
    if (cmd.load_a && (cnt_a_r < CNT_MAX)) begin
      mem_a[cnt_a_r[IDX_W-1:0]] <= in_data;
    end
    if (cmd.load_b && (cnt_b_r < CNT_MAX)) begin
      mem_b[cnt_b_r[IDX_W-1:0]] <= in_data;
    end
    if (cmd.fetch) begin
      a_q_r <= mem_a[i_r[IDX_W-1:0]];
      b_q_r <= mem_b[j_r[IDX_W-1:0]];
    end
  end

  // entry counts
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
    end else begin
      if (cmd.load_a && (cnt_a_r < CNT_MAX)) cnt_a_r <= cnt_a_r + CNT_W'(1);
      if (cmd.load_b && (cnt_b_r < CNT_MAX)) cnt_b_r <= cnt_b_r + CNT_W'(1);
    end
  end

  // merge decision on the fetched heads
  logic                   a_left, b_left, take_a, take_b;
  logic [COORD_W-1:0]     a_row, a_col, b_row, b_col;
  logic signed [SUM_W-1:0] a_val, b_val;
  logic [COORD_W-1:0]     sel_row, sel_col;
  logic signed [SUM_W-1:0] sel_val;

  always_comb begin
    a_row  = a_q_r[15:0];
    a_col  = a_q_r[31:16];
    a_val  = SUM_W'(signed'(a_q_r[47:32]));
    b_row  = b_q_r[15:0];
    b_col  = b_q_r[31:16];
    b_val  = SUM_W'(signed'(b_q_r[47:32]));
    a_left = (i_r < cnt_a_r);
    b_left = (j_r < cnt_b_r);
    take_a = 1'b0;
    take_b = 1'b0;
    if (a_left && b_left) begin
      take_a = (a_row < b_row) || ((a_row == b_row) && (a_col < b_col));
      take_b = (a_row > b_row) || ((a_row == b_row) && (a_col > b_col));
    end else if (a_left) begin
      take_a = 1'b1;
    end else begin
      take_b = 1'b1;
    end
    if (take_a) begin
      sel_row = a_row;
      sel_col = a_col;
      sel_val = a_val;
    end else if (take_b) begin
      sel_row = b_row;
      sel_col = b_col;
      sel_val = b_val;
    end else begin
      sel_row = a_row;
      sel_col = a_col;
      sel_val = a_val + b_val;
    end
    i_nxt = i_r + ((take_a || !take_b) ? CNT_W'(1) : CNT_W'(0));
    j_nxt = j_r + ((take_b || !take_a) ? CNT_W'(1) : CNT_W'(0));
  end

  // merge pointers
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.emit_entry) begin
      i_r <= i_nxt;
      j_r <= j_nxt;
    end
  end

  // output register
  logic                    out_valid_r;
  logic [COORD_W-1:0]      o_row_r, o_col_r;
  logic signed [SUM_W-1:0] o_val_r;
  logic [STAT_W-1:0]       o_stat_r;
  logic                    o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_entry || cmd.emit_status) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status) begin
      o_row_r  <= '0;
      o_col_r  <= '0;
      o_val_r  <= '0;
      o_stat_r <= cmd.status;
      o_last_r <= 1'b1;
    end else if (cmd.emit_entry) begin
      o_row_r  <= sel_row;
      o_col_r  <= sel_col;
      o_val_r  <= sel_val;
      o_stat_r <= STAT_ENTRY;
      o_last_r <= stat.merge_done;
    end
  end

  // status back to the controller
  always_comb begin
    stat.dims_differ = (rows_a_r != rows_b_r) || (cols_a_r != cols_b_r);
    stat.both_empty  = (cnt_a_r == '0) && (cnt_b_r == '0);
    stat.out_free    = !out_valid_r || out_ready;
    stat.merge_done  = (i_nxt >= cnt_a_r) && (j_nxt >= cnt_b_r);
  end

  assign out_valid  = out_valid_r;
  assign out_data   = {7'd0, o_val_r, o_col_r, o_row_r};
  assign out_status = o_stat_r;
  assign out_last   = o_last_r;

endmodule

/* tb/scma_sum_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scma_sum_checker
// Watches the config port and both streams of the matrix add unit, keeps its
// own copy of the two coordinate lists and dimensions, predicts each merge
// and compares every result beat field by field against the oldest one due.
// ----------------------------------------------------------------------------
module scma_sum_checker #(
  parameter int MAX_TERMS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [scma_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [scma_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [scma_pkg::IN_DW-1:0]    in_tdata,   // row[15:0], col[31:16], value[47:32]
  input  logic [scma_pkg::FUNC_W-1:0]   in_tuser,   // func[1:0]
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [scma_pkg::OUT_DW-1:0]   out_tdata,  // out_row[15:0], out_col[31:16],
                                                    // out_value[48:32], zero pad
  input  logic [scma_pkg::STAT_W-1:0]   out_tuser,  // status[1:0]
  input  logic                          out_tlast,
  output int                            fail_count,
  output int                            pending_count,
  output int                            results_checked
);
  import scma_pkg::*;

  // one stored matrix term, laid out as on in_tdata
  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } coord_entry_t;

  // one predicted result beat
  typedef struct {
    logic [COORD_W-1:0]      row;
    logic [COORD_W-1:0]      col;
    logic signed [SUM_W-1:0] value;
    logic [STAT_W-1:0]       status;
    logic                    last;
  } sum_beat_t;

  coord_entry_t       mat_a [MAX_TERMS];
  coord_entry_t       mat_b [MAX_TERMS];
  int unsigned        len_a, len_b;
  logic [CFG_W-1:0]   dim_rows_a, dim_cols_a, dim_rows_b, dim_cols_b;
  sum_beat_t          sums_due [$];
  int                 errors;
  int                 n_checked;

  task automatic report_error(string what, int got, int want);
    $display("[%0t] result beat %0d: %s got %0d, want %0d", $realtime, n_checked, what,
             got, want);
    errors++;
  endtask

  function automatic void push_sum(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                   logic signed [SUM_W-1:0] value, logic [STAT_W-1:0] status);
    sum_beat_t s;
    s.row    = row;
    s.col    = col;
    s.value  = value;
    s.status = status;
    s.last   = 1'b0;
    sums_due.push_back(s);
  endfunction

  // two-pointer walk over both lists in row-major order, sums on equal keys
  function automatic void predict_merge();
    int unsigned             i, j;
    logic [31:0]             key_a, key_b;
    logic signed [SUM_W-1:0] sum;
    if (dim_rows_a != dim_rows_b || dim_cols_a != dim_cols_b) begin
      push_sum('0, '0, '0, STAT_MISMATCH);
    end else if (len_a == 0 && len_b == 0) begin
      push_sum('0, '0, '0, STAT_EMPTY);
    end else begin
      i = 0;
      j = 0;
      while (i < len_a && j < len_b) begin
        key_a = {mat_a[i].row, mat_a[i].col};
        key_b = {mat_b[j].row, mat_b[j].col};
        if (key_a < key_b) begin
          push_sum(mat_a[i].row, mat_a[i].col, SUM_W'($signed(mat_a[i].value)), STAT_ENTRY);
          i++;
        end else if (key_a > key_b) begin
          push_sum(mat_b[j].row, mat_b[j].col, SUM_W'($signed(mat_b[j].value)), STAT_ENTRY);
          j++;
        end else begin
          sum = SUM_W'($signed(mat_a[i].value));
          sum = sum + SUM_W'($signed(mat_b[j].value));
          push_sum(mat_a[i].row, mat_a[i].col, sum, STAT_ENTRY);
          i++;
          j++;
        end
      end
      for (; i < len_a; i++)
        push_sum(mat_a[i].row, mat_a[i].col, SUM_W'($signed(mat_a[i].value)), STAT_ENTRY);
      for (; j < len_b; j++)
        push_sum(mat_b[j].row, mat_b[j].col, SUM_W'($signed(mat_b[j].value)), STAT_ENTRY);
    end
    sums_due[sums_due.size()-1].last = 1'b1;
    len_a = 0;
    len_b = 0;
  endfunction

  always @(posedge clk) begin
    sum_beat_t               want;
    logic signed [SUM_W-1:0] got_value;
    if (!rst_n) begin
      len_a      = 0;
      len_b      = 0;
      dim_rows_a = CFG_W'(1);
      dim_cols_a = CFG_W'(1);
      dim_rows_b = CFG_W'(1);
      dim_cols_b = CFG_W'(1);
      sums_due.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_ROWS_A: dim_rows_a = cfg_wdata;
          REG_COLS_A: dim_cols_a = cfg_wdata;
          REG_ROWS_B: dim_rows_b = cfg_wdata;
          REG_COLS_B: dim_cols_b = cfg_wdata;
          default: ;
        endcase
      end

      // input beat: append a term or predict a merge, full lists drop loads
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          FUNC_LOAD_A: if (len_a < MAX_TERMS) begin
            mat_a[len_a] = in_tdata;
            len_a++;
          end
          FUNC_LOAD_B: if (len_b < MAX_TERMS) begin
            mat_b[len_b] = in_tdata;
            len_b++;
          end
          FUNC_MERGE: predict_merge();
          default: ;
        endcase
      end

      // result beat against the oldest prediction
      if (out_tvalid && out_tready) begin
        got_value = $signed(out_tdata[48:32]);
        if (sums_due.size() == 0) begin
          report_error("beat with nothing pending, row", int'(out_tdata[15:0]), 0);
        end else begin
          want = sums_due.pop_front();
          if (out_tdata[15:0] !== want.row)
            report_error("out_row", int'(out_tdata[15:0]), int'(want.row));
          if (out_tdata[31:16] !== want.col)
            report_error("out_col", int'(out_tdata[31:16]), int'(want.col));
          if (got_value !== want.value)
            report_error("out_value", int'(got_value), int'(want.value));
          if (out_tuser !== want.status)
            report_error("status", int'(out_tuser), int'(want.status));
          if (out_tlast !== want.last)
            report_error("last", int'(out_tlast), int'(want.last));
        end
        n_checked++;
      end
    end
    fail_count      <= errors;
    pending_count   <= sums_due.size();
    results_checked <= n_checked;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the sparse coordinate matrix add unit: a directed pass over extreme
// values, zero sums, empty and unsorted lists and dimension mismatches, then
// random, mostly sorted list pairs with shared keys, overflowing lists and noise,
// under random idling on both streams. Checking is done by scma_sum_checker.
// ----------------------------------------------------------------------------
module testbench;
  import scma_pkg::*;

  localparam int                MAX_TERMS   = 32;
  localparam int                NUM_ITEMS   = 450;
  localparam int                QUIET_GAP   = 8;      // load or final emit still in flight
  localparam int                LONG_HOLD   = 400;
  localparam int                END_LIMIT   = 50000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;   // row[15:0], col[31:16], value[47:32]
  logic [FUNC_W-1:0]   in_tuser;   // func[1:0]
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;  // out_row[15:0], out_col[31:16], out_value[48:32], zero pad
  logic [STAT_W-1:0]   out_tuser;  // status[1:0]
  logic                out_tlast;

  int fail_count, pending_count, results_checked;
  int items_sent, merges_sent, dim_settings, hold_reqs;
  bit tx_idle;

  sparse_coordinate_matrix_add_unit #(.MAX_TERMS(MAX_TERMS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  scma_sum_checker #(.MAX_TERMS(MAX_TERMS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // hard stop
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: per-beat random stall in stretches, plus a requested long hold
  initial begin
    int stall_left;
    int mode_left;
    int hold_seen;
    bit rx_stall;
    stall_left = 0;
    mode_left  = 0;
    hold_seen  = 0;
    rx_stall   = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (mode_left == 0) begin
          rx_stall  = $urandom_range(0, 3) != 0;
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        stall_left = rx_stall ? $urandom_range(0, 11) : 0;
      end
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen  = hold_reqs;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // one input beat, returns right after the accepting edge
  task automatic send_beat(logic [FUNC_W-1:0] func, logic [COORD_W-1:0] row,
                           logic [COORD_W-1:0] col, logic [VAL_W-1:0] value);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = func;
    in_tdata  = {value, col, row};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    if (func != FUNC_UNUSED) items_sent++;
    if (func == FUNC_MERGE) merges_sent++;
  endtask

  // stop sending and wait for every predicted result plus the tail of the block
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (QUIET_GAP) @(posedge clk);
  endtask

  task automatic write_dims(logic [CFG_W-1:0] ra, logic [CFG_W-1:0] ca,
                            logic [CFG_W-1:0] rb, logic [CFG_W-1:0] cb);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1; cfg_addr = REG_ROWS_A; cfg_wdata = ra;
    @(negedge clk);
    cfg_addr = REG_COLS_A; cfg_wdata = ca;
    @(negedge clk);
    cfg_addr = REG_ROWS_B; cfg_wdata = rb;
    @(negedge clk);
    cfg_addr = REG_COLS_B; cfg_wdata = cb;
    @(negedge clk);
    cfg_we = 1'b0;
    dim_settings++;
  endtask

  // mostly short lists, sometimes long, sometimes past capacity
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 85) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 20);
    return $urandom_range(28, 36);
  endfunction

  // coordinate from a small grid, the full range, or the edges
  function automatic logic [COORD_W-1:0] pick_coord(int mode);
    case (mode)
      0: return COORD_W'($urandom_range(0, 7));
      1: return COORD_W'($urandom);
      default: case ($urandom_range(0, 4))
        0: return 16'h0000;
        1: return 16'h0001;
        2: return 16'hFFFE;
        3: return 16'hFFFF;
        default: return COORD_W'($urandom);
      endcase
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 16'h0000;
    if (r < 8) return 16'h7FFF;
    if (r < 13) return 16'h8000;
    return VAL_W'($urandom);
  endfunction

  // load two lists, interleaved at random, then merge
  task automatic run_lists(int n_a, int n_b, bit sorted);
    logic [31:0] keys_a[$];
    logic [31:0] keys_b[$];
    int          mode;
    int          ia, ib;
    mode = $urandom_range(0, 2);
    repeat (n_a) keys_a.push_back({pick_coord(mode), pick_coord(mode)});
    repeat (n_b) begin
      if (keys_a.size() > 0 && $urandom_range(0, 1))
        keys_b.push_back(keys_a[$urandom_range(0, keys_a.size() - 1)]);
      else
        keys_b.push_back({pick_coord(mode), pick_coord(mode)});
    end
    if (sorted) begin
      keys_a.sort();
      keys_b.sort();
    end else begin
      keys_a.shuffle();
      keys_b.shuffle();
    end
    ia = 0;
    ib = 0;
    while (ia < n_a || ib < n_b) begin
      if ($urandom_range(0, 24) == 0)
        send_beat(FUNC_UNUSED, COORD_W'($urandom), COORD_W'($urandom), VAL_W'($urandom));
      if (ib >= n_b || (ia < n_a && $urandom_range(0, 1))) begin
        send_beat(FUNC_LOAD_A, keys_a[ia][31:16], keys_a[ia][15:0], pick_value());
        ia++;
      end else begin
        send_beat(FUNC_LOAD_B, keys_b[ib][31:16], keys_b[ib][15:0], pick_value());
        ib++;
      end
    end
    send_beat(FUNC_MERGE, COORD_W'($urandom), COORD_W'($urandom), VAL_W'($urandom));
  endtask

  // new dimensions: matching, matching at the edges, rows apart or cols apart
  task automatic write_random_dims();
    logic [CFG_W-1:0] ra, ca, rb, cb;
    ra = CFG_W'($urandom_range(1, 65535));
    ca = CFG_W'($urandom_range(1, 65535));
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        rb = ra;
        cb = ca;
      end
      3: begin
        ra = $urandom_range(0, 1) ? 16'd1 : 16'hFFFF;
        ca = $urandom_range(0, 1) ? 16'd1 : 16'hFFFF;
        rb = ra;
        cb = ca;
      end
      4: begin
        do rb = CFG_W'($urandom_range(1, 65535)); while (rb == ra);
        cb = ca;
      end
      default: begin
        rb = ra;
        do cb = CFG_W'($urandom_range(1, 65535)); while (cb == ca);
      end
    endcase
    write_dims(ra, ca, rb, cb);
  endtask

  initial begin
    int  waited;
    bit  held;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_ROWS_A;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FUNC_LOAD_A;
    tx_idle   = 1'b1;
    held      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // both lists empty after reset
    send_beat(FUNC_MERGE, 16'h0000, 16'h0000, 16'h0000);
    // largest positive sum, a zero sum, most negative sum
    send_beat(FUNC_LOAD_A, 16'h0000, 16'h0000, 16'h7FFF);
    send_beat(FUNC_LOAD_B, 16'h0000, 16'h0000, 16'h7FFF);
    send_beat(FUNC_LOAD_A, 16'h0000, 16'h0005, 16'd100);
    send_beat(FUNC_LOAD_B, 16'h0000, 16'h0005, 16'hFF9C);
    send_beat(FUNC_LOAD_A, 16'hFFFF, 16'hFFFF, 16'h8000);
    send_beat(FUNC_LOAD_B, 16'hFFFF, 16'hFFFF, 16'h8000);
    send_beat(FUNC_MERGE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // ignored func code
    send_beat(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // only one list holds anything
    send_beat(FUNC_LOAD_A, 16'd1, 16'd2, 16'd3);
    send_beat(FUNC_MERGE, 16'h0000, 16'h0000, 16'h0000);
    send_beat(FUNC_LOAD_B, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_beat(FUNC_MERGE, 16'h0000, 16'h0000, 16'h0000);
    // unsorted list a
    send_beat(FUNC_LOAD_A, 16'd5, 16'd5, 16'd1);
    send_beat(FUNC_LOAD_A, 16'd1, 16'd1, 16'd2);
    send_beat(FUNC_LOAD_B, 16'd3, 16'd3, 16'd3);
    send_beat(FUNC_MERGE, 16'h0000, 16'h0000, 16'h0000);
    // rows differ: mismatch, lists cleared, then again on empty lists
    write_dims(16'hFFFF, 16'd1, 16'd1, 16'd1);
    send_beat(FUNC_LOAD_A, 16'd2, 16'd2, 16'd2);
    send_beat(FUNC_MERGE, 16'h0000, 16'h0000, 16'h0000);
    send_beat(FUNC_MERGE, 16'h0000, 16'h0000, 16'h0000);
    // largest matching dims, lists must be empty now
    write_dims(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(FUNC_MERGE, 16'h0000, 16'h0000, 16'h0000);
    // cols differ
    write_dims(16'd1, 16'd7, 16'd1, 16'd8);
    send_beat(FUNC_MERGE, 16'h0000, 16'h0000, 16'h0000);
    write_dims(16'd1, 16'd1, 16'd1, 16'd1);

    // random list pairs
    while (items_sent < NUM_ITEMS) begin
      if (!held && items_sent > NUM_ITEMS / 2) begin
        // result side holds off while two overfull merges are pushed in
        held = 1'b1;
        wait_drained();
        hold_reqs++;
        tx_idle = 1'b0;
        run_lists(34, 34, 1'b1);
        run_lists(MAX_TERMS, 33, 1'b1);
      end
      case ($urandom_range(0, 19))
        0, 1, 2: write_random_dims();
        3:       wait_drained();
        default: ;
      endcase
      tx_idle = $urandom_range(0, 3) != 0;
      run_lists(pick_count(), pick_count(), $urandom_range(0, 9) != 0);
    end

    // drain
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (2) @(posedge clk);
    waited = 0;
    while (pending_count != 0 && waited < END_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4 * QUIET_GAP) @(posedge clk);

    $display("covered %0d input beats with %0d merges, %0d result beats checked",
             items_sent, merges_sent, results_checked);
    $display("%0d dimension settings incl. edge values and mismatches, one long output hold",
             dim_settings);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
